// ===== design/sub_octave_bass_booster_macros.svh =====
// Assertion macros used by the sub-octave bass booster controller.
`ifndef SUB_OCTAVE_BASS_BOOSTER_MACROS_SVH
`define SUB_OCTAVE_BASS_BOOSTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOBB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SOBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobb: next-cycle check failed");

`endif

// ===== design/sobb_pkg.sv =====
package sobb_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;

  // Filter state is signed Q8.24.
  localparam int STATE_W    = 32;
  localparam int STATE_FRAC = STATE_W - 8;
  localparam int WIDE_W     = STATE_W + 1;
  localparam int OPND_W     = STATE_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int COEF_SHIFT = 16;

  localparam int GAIN_W = 17;
  localparam int COEF_W = 16;
  localparam int DC_W   = 16;
  localparam int TRIM_W = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_ROOT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EQ_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DC_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASS_TRIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN  = 3'd6;

  localparam logic [GAIN_W-1:0] ROOT_GAIN_RST = 17'd65536;
  localparam logic [GAIN_W-1:0] SUB_GAIN_RST  = 17'd0;
  localparam logic [COEF_W-1:0] EQ_COEF_RST   = 16'd655;
  localparam logic [DC_W-1:0]   DC_STEP_RST   = 16'd524;
  localparam logic [TRIM_W-1:0] BASS_TRIM_RST = 18'd131072;
  localparam logic [GAIN_W-1:0] WET_GAIN_RST  = 17'd65536;
  localparam logic [GAIN_W-1:0] DRY_GAIN_RST  = 17'd0;

  // Operand selection for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE, MUL_ENV, MUL_SUB, MUL_ROOT, MUL_INT, MUL_SQ, MUL_CUBE,
    MUL_LIM, MUL_TRIM, MUL_DRY, MUL_LP1, MUL_LP2, MUL_WET
  } mul_op_t;

  // What is done with the latest registered product.
  typedef enum logic [3:0] {
    WB_NONE, WB_ENV, WB_SUB, WB_ROOT, WB_INT, WB_SQ, WB_CUBE, WB_LIM,
    WB_DC, WB_TRIM, WB_DRY, WB_LP1, WB_LP2, WB_WET
  } wb_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul;
    wb_op_t  wb;
  } sobb_cmd_t;

  function automatic logic signed [WIDE_W:0] ext_state(input logic signed [STATE_W-1:0] v);
    return {{2{v[STATE_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W:0] ext_wide(input logic signed [WIDE_W-1:0] v);
    return {v[WIDE_W-1], v};
  endfunction

  // Saturate a shifted product to the wide (33 bit) range.
  function automatic logic signed [WIDE_W-1:0] sat_w(input logic signed [PROD_W-1:0] v);
    logic fits;
    fits = (&v[PROD_W-1:WIDE_W-1]) || !(|v[PROD_W-1:WIDE_W-1]);
    return fits ? v[WIDE_W-1:0] : {v[PROD_W-1], {(WIDE_W-1){~v[PROD_W-1]}}};
  endfunction

  // Saturate a shifted product to the state range.
  function automatic logic signed [STATE_W-1:0] sat_s(input logic signed [PROD_W-1:0] v);
    logic fits;
    fits = (&v[PROD_W-1:STATE_W-1]) || !(|v[PROD_W-1:STATE_W-1]);
    return fits ? v[STATE_W-1:0] : {v[PROD_W-1], {(STATE_W-1){~v[PROD_W-1]}}};
  endfunction

  // Saturate an accumulator sum to the state range.
  function automatic logic signed [STATE_W-1:0] sat_acc(input logic signed [WIDE_W:0] v);
    logic fits;
    fits = (&v[WIDE_W:STATE_W-1]) || !(|v[WIDE_W:STATE_W-1]);
    return fits ? v[STATE_W-1:0] : {v[WIDE_W], {(STATE_W-1){~v[WIDE_W]}}};
  endfunction

endpackage

// ===== design/sobb_ctrl.sv =====
`include "sub_octave_bass_booster_macros.svh"

module sobb_ctrl import sobb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sobb_cmd_t cmd
);

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] ST_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] ST_ENV_M  = 5'd1;
  localparam logic [STEP_W-1:0] ST_ENV_W  = 5'd2;
  localparam logic [STEP_W-1:0] ST_SUB_M  = 5'd3;
  localparam logic [STEP_W-1:0] ST_ROOT_M = 5'd4;
  localparam logic [STEP_W-1:0] ST_ROOT_W = 5'd5;
  localparam logic [STEP_W-1:0] ST_INT_M  = 5'd6;
  localparam logic [STEP_W-1:0] ST_INT_W  = 5'd7;
  localparam logic [STEP_W-1:0] ST_SQ_M   = 5'd8;
  localparam logic [STEP_W-1:0] ST_SQ_W   = 5'd9;
  localparam logic [STEP_W-1:0] ST_CUBE_M = 5'd10;
  localparam logic [STEP_W-1:0] ST_CUBE_W = 5'd11;
  localparam logic [STEP_W-1:0] ST_LIM_M  = 5'd12;
  localparam logic [STEP_W-1:0] ST_LIM_W  = 5'd13;
  localparam logic [STEP_W-1:0] ST_DC     = 5'd14;
  localparam logic [STEP_W-1:0] ST_TRIM_M = 5'd15;
  localparam logic [STEP_W-1:0] ST_DRY_M  = 5'd16;
  localparam logic [STEP_W-1:0] ST_LP1_M  = 5'd17;
  localparam logic [STEP_W-1:0] ST_LP1_W  = 5'd18;
  localparam logic [STEP_W-1:0] ST_LP2_M  = 5'd19;
  localparam logic [STEP_W-1:0] ST_LP2_W  = 5'd20;
  localparam logic [STEP_W-1:0] ST_WET_M  = 5'd21;
  localparam logic [STEP_W-1:0] ST_WET_W  = 5'd22;

  logic [STEP_W-1:0] step, step_next;
  logic              slot_free;

  // No request is taken while reset is held.
  assign in_ready  = (step == ST_IDLE) && !rst;
  assign slot_free = !out_valid || out_ready;

  // Each step may write back the previous product and start the next one
  // in the same cycle when the two do not depend on each other.
  always_comb begin
    cmd       = '{load: 1'b0, mul: MUL_NONE, wb: WB_NONE};
    step_next = step;
    unique case (step)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_next = ST_ENV_M;
        end
      end
      ST_ENV_M:  begin cmd.mul = MUL_ENV;  step_next = ST_ENV_W;  end
      ST_ENV_W:  begin cmd.wb  = WB_ENV;   step_next = ST_SUB_M;  end
      ST_SUB_M:  begin cmd.mul = MUL_SUB;  step_next = ST_ROOT_M; end
      ST_ROOT_M: begin
        cmd.wb    = WB_SUB;
        cmd.mul   = MUL_ROOT;
        step_next = ST_ROOT_W;
      end
      ST_ROOT_W: begin cmd.wb  = WB_ROOT;  step_next = ST_INT_M;  end
      ST_INT_M:  begin cmd.mul = MUL_INT;  step_next = ST_INT_W;  end
      ST_INT_W:  begin cmd.wb  = WB_INT;   step_next = ST_SQ_M;   end
      ST_SQ_M:   begin cmd.mul = MUL_SQ;   step_next = ST_SQ_W;   end
      ST_SQ_W:   begin cmd.wb  = WB_SQ;    step_next = ST_CUBE_M; end
      ST_CUBE_M: begin cmd.mul = MUL_CUBE; step_next = ST_CUBE_W; end
      ST_CUBE_W: begin cmd.wb  = WB_CUBE;  step_next = ST_LIM_M;  end
      ST_LIM_M:  begin cmd.mul = MUL_LIM;  step_next = ST_LIM_W;  end
      ST_LIM_W:  begin cmd.wb  = WB_LIM;   step_next = ST_DC;     end
      ST_DC:     begin cmd.wb  = WB_DC;    step_next = ST_TRIM_M; end
      ST_TRIM_M: begin cmd.mul = MUL_TRIM; step_next = ST_DRY_M;  end
      ST_DRY_M:  begin
        cmd.wb    = WB_TRIM;
        cmd.mul   = MUL_DRY;
        step_next = ST_LP1_M;
      end
      ST_LP1_M:  begin
        cmd.wb    = WB_DRY;
        cmd.mul   = MUL_LP1;
        step_next = ST_LP1_W;
      end
      ST_LP1_W:  begin cmd.wb  = WB_LP1;   step_next = ST_LP2_M;  end
      ST_LP2_M:  begin cmd.mul = MUL_LP2;  step_next = ST_LP2_W;  end
      ST_LP2_W:  begin cmd.wb  = WB_LP2;   step_next = ST_WET_M;  end
      ST_WET_M:  begin cmd.mul = MUL_WET;  step_next = ST_WET_W;  end
      ST_WET_W: begin
        // The final mix waits here until the output register is free.
        if (slot_free) begin
          cmd.wb    = WB_WET;
          step_next = ST_IDLE;
        end
      end
      default: step_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (step == ST_WET_W && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SOBB_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, step == ST_ENV_M)
  `SOBB_ASSERT_SAME(a_out_from_mix, clk, rst, $rose(out_valid), $past(step) == ST_WET_W)
  `SOBB_ASSERT_NEXT(a_busy_advances, clk, rst, step != ST_IDLE && step != ST_WET_W, step != $past(step))

endmodule

// ===== design/sobb_datapath.sv =====
module sobb_datapath import sobb_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           last_in,
  input  sobb_cmd_t                      cmd,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           last_out
);

  localparam int XW = SAMPLE_WIDTH + STATE_FRAC;
  localparam int OW = WIDE_W + SAMPLE_WIDTH;

  logic [GAIN_W-1:0] root_gain, sub_gain, wet_gain, dry_gain;
  logic [COEF_W-1:0] eq_coef;
  logic [DC_W-1:0]   dc_step;
  logic [TRIM_W-1:0] bass_trim;

  logic was_negative, sub_phase, last_hold;
  logic signed [STATE_W-1:0] xs, envelope_lowpass, integrator, lowpass_one, lowpass_two;
  logic signed [STATE_W-1:0] r_acc, cube;
  logic signed [WIDE_W:0]    r_sub;
  logic signed [WIDE_W-1:0]  mix_dry;
  logic signed [PROD_W-1:0]  prod;

  logic signed [OPND_W-1:0] opa, opb;
  logic signed [XW-1:0]     x_ext, x_scaled;
  logic                     x_pos, integ_pos;
  logic signed [PROD_W-1:0] sh16, sh24;
  logic signed [WIDE_W-1:0] p_wide;
  logic signed [STATE_W-1:0] p_state, p_cube;
  logic signed [WIDE_W:0]   dc_ext, env_abs;
  logic signed [WIDE_W:0]   mix_sum;
  logic signed [WIDE_W-1:0] mix_sat;
  logic signed [OW-1:0]     mix_ext, mix_scaled;
  logic                     mix_fits;
  logic signed [SAMPLE_WIDTH-1:0] mix_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_gain <= ROOT_GAIN_RST;
      sub_gain  <= SUB_GAIN_RST;
      eq_coef   <= EQ_COEF_RST;
      dc_step   <= DC_STEP_RST;
      bass_trim <= BASS_TRIM_RST;
      wet_gain  <= WET_GAIN_RST;
      dry_gain  <= DRY_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROOT_GAIN: root_gain <= cfg_data[GAIN_W-1:0];
        REG_SUB_GAIN:  sub_gain  <= cfg_data[GAIN_W-1:0];
        REG_EQ_COEF:   eq_coef   <= cfg_data[COEF_W-1:0];
        REG_DC_STEP:   dc_step   <= cfg_data[DC_W-1:0];
        REG_BASS_TRIM: bass_trim <= cfg_data[TRIM_W-1:0];
        REG_WET_GAIN:  wet_gain  <= cfg_data[GAIN_W-1:0];
        REG_DRY_GAIN:  dry_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input to Q8.24: widen, then shift so that narrowing rounds down.
  assign x_ext    = {{STATE_FRAC{sample_in[SAMPLE_WIDTH-1]}}, sample_in};
  assign x_scaled = (x_ext <<< STATE_FRAC) >>> (SAMPLE_WIDTH - 1);
  assign x_pos    = !sample_in[SAMPLE_WIDTH-1] && (sample_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      was_negative <= 1'b0;
      sub_phase    <= 1'b0;
    end else if (cmd.load) begin
      if (x_pos) begin
        if (was_negative) begin
          sub_phase <= ~sub_phase;
        end
        was_negative <= 1'b0;
      end else begin
        was_negative <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs        <= x_scaled[STATE_W-1:0];
      last_hold <= last_in;
    end
  end

  assign env_abs = envelope_lowpass[STATE_W-1] ? -ext_state(envelope_lowpass)
                                               : ext_state(envelope_lowpass);

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.mul)
      MUL_ENV: begin
        opa = {xs[STATE_W-1], xs} - {envelope_lowpass[STATE_W-1], envelope_lowpass};
        opb = {{(OPND_W-COEF_W){1'b0}}, eq_coef};
      end
      MUL_SUB: begin
        opa = env_abs[WIDE_W-1:0];
        opb = {{(OPND_W-GAIN_W){1'b0}}, sub_gain};
      end
      MUL_ROOT: begin
        opa = {xs[STATE_W-1], xs};
        opb = {{(OPND_W-GAIN_W){1'b0}}, root_gain};
      end
      MUL_INT: begin
        opa = {r_acc[STATE_W-1], r_acc};
        opb = {{(OPND_W-COEF_W){1'b0}}, eq_coef};
      end
      MUL_SQ: begin
        opa = {integrator[STATE_W-1], integrator};
        opb = {integrator[STATE_W-1], integrator};
      end
      MUL_CUBE: begin
        opa = {cube[STATE_W-1], cube};
        opb = {integrator[STATE_W-1], integrator};
      end
      MUL_LIM: begin
        opa = {cube[STATE_W-1], cube};
        opb = {{(OPND_W-COEF_W){1'b0}}, eq_coef};
      end
      MUL_TRIM: begin
        opa = {integrator[STATE_W-1], integrator};
        opb = {{(OPND_W-TRIM_W){1'b0}}, bass_trim};
      end
      MUL_DRY: begin
        opa = {xs[STATE_W-1], xs};
        opb = {{(OPND_W-GAIN_W){1'b0}}, dry_gain};
      end
      MUL_LP1: begin
        opa = {r_acc[STATE_W-1], r_acc} - {lowpass_one[STATE_W-1], lowpass_one};
        opb = {{(OPND_W-COEF_W){1'b0}}, eq_coef};
      end
      MUL_LP2: begin
        opa = {lowpass_one[STATE_W-1], lowpass_one} - {lowpass_two[STATE_W-1], lowpass_two};
        opb = {{(OPND_W-COEF_W){1'b0}}, eq_coef};
      end
      MUL_WET: begin
        opa = {lowpass_two[STATE_W-1], lowpass_two};
        opb = {{(OPND_W-GAIN_W){1'b0}}, wet_gain};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) begin
      prod <= PROD_W'(opa) * PROD_W'(opb);
    end
  end

  // Arithmetic right shifts round the exact product toward minus infinity.
  assign sh16    = prod >>> COEF_SHIFT;
  assign sh24    = prod >>> STATE_FRAC;
  assign p_wide  = sat_w(sh16);
  assign p_state = sat_s(sh16);
  assign p_cube  = sat_s(sh24);

  assign dc_ext    = {{(WIDE_W+1-DC_W){1'b0}}, dc_step};
  assign integ_pos = !integrator[STATE_W-1] && (integrator != '0);

  // Final mix, then back to the sample format with floor and saturation.
  assign mix_sum    = ext_wide(mix_dry) + ext_wide(p_wide);
  assign mix_sat    = (mix_sum[WIDE_W] == mix_sum[WIDE_W-1]) ? mix_sum[WIDE_W-1:0]
                      : {mix_sum[WIDE_W], {(WIDE_W-1){~mix_sum[WIDE_W]}}};
  assign mix_ext    = {{SAMPLE_WIDTH{mix_sat[WIDE_W-1]}}, mix_sat};
  assign mix_scaled = (mix_ext <<< (SAMPLE_WIDTH - 1)) >>> STATE_FRAC;
  assign mix_fits   = (&mix_scaled[OW-1:SAMPLE_WIDTH-1]) || !(|mix_scaled[OW-1:SAMPLE_WIDTH-1]);
  assign mix_out    = mix_fits ? mix_scaled[SAMPLE_WIDTH-1:0]
                      : {mix_scaled[OW-1], {(SAMPLE_WIDTH-1){~mix_scaled[OW-1]}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope_lowpass <= '0;
      integrator       <= '0;
      lowpass_one      <= '0;
      lowpass_two      <= '0;
    end else begin
      case (cmd.wb)
        WB_ENV:  envelope_lowpass <= sat_acc(ext_state(envelope_lowpass) + ext_wide(p_wide));
        WB_INT:  integrator <= sat_acc(ext_state(integrator) + ext_wide(p_wide));
        WB_LIM:  integrator <= sat_acc(ext_state(integrator) - ext_wide(p_wide));
        WB_DC: begin
          // A zero integrator is pulled up, not down.
          if (integ_pos) begin
            integrator <= sat_acc(ext_state(integrator) - dc_ext);
          end else begin
            integrator <= sat_acc(ext_state(integrator) + dc_ext);
          end
        end
        WB_LP1:  lowpass_one <= sat_acc(ext_state(lowpass_one) + ext_wide(p_wide));
        WB_LP2:  lowpass_two <= sat_acc(ext_state(lowpass_two) + ext_wide(p_wide));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.wb)
      WB_SUB:  r_sub   <= sub_phase ? ext_wide(p_wide) : -ext_wide(p_wide);
      WB_ROOT: r_acc   <= sat_acc(r_sub + ext_wide(p_wide));
      WB_SQ:   cube    <= p_cube;
      WB_CUBE: cube    <= p_cube;
      WB_TRIM: r_acc   <= p_state;
      WB_DRY:  mix_dry <= p_wide;
      WB_WET: begin
        sample_out <= mix_out;
        last_out   <= last_hold;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/sub_octave_bass_booster.sv =====
// Sub-octave bass booster: one signed sample in, one processed sample out over
// valid/ready channels, with seven gain and coefficient registers written over a
// separate channel that is ready whenever reset is low. Each sample is taken in the
// idle state and then runs through 22 steps of a controller that drives a single
// shared 33 by 33 bit multiplier with a registered product, twelve products in
// all, each written back with floor rounding and saturation in the cycle after it
// is formed, save the final mix, which waits for a free output register. A new
// sample is taken only once the previous one has finished its steps; the result
// then waits in the output register to be taken while the next sample starts.
module sub_octave_bass_booster import sobb_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           last_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           last_out
);

  sobb_cmd_t cmd;

  assign cfg_ready = !rst;

  sobb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sobb_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .cmd        (cmd),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

endmodule
